// ===== design/cpt_pkg.sv =====
// shared constants, control type and sine table generator for the clarke/park transform
package cpt_pkg;

  // default geometry of the block
  localparam int DEF_DATA_BITS       = 16;
  localparam int DEF_ANGLE_BITS      = 16;
  localparam int DEF_SINE_TABLE_BITS = 10;

  // q15 transform coefficients, 17-bit signed so they share the trig multiplier inputs
  localparam logic signed [16:0] K_INV_SQRT3     = 17'sd18919;
  localparam logic signed [16:0] K_TWO_INV_SQRT3 = 17'sd37837;
  localparam logic signed [16:0] K_SQRT3_HALF    = 17'sd28378;
  localparam logic signed [16:0] K_HALF          = 17'sd16384;

  // half of one lsb after the q15 shift
  localparam int ROUND_Q15 = 16384;

  // q30 constants of the table generator
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

  // control that travels beside each word
  typedef struct packed {
    logic valid;
    logic inverse;
  } ctrl_t;

  // quarter-wave sine entry k in q15, integer taylor evaluation in q30
  function automatic logic [14:0] sine_entry(input int unsigned table_bits,
                                             input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    int unsigned qsh;
    qsh = table_bits - 2;
    x  = ((64'(k) * HALFPI_Q30) + (64'd1 << (qsh - 1))) >> qsh;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

endpackage

// ===== design/cpt_sine_rom.sv =====
// quarter-wave sine/cosine lookup with registered reads
module cpt_sine_rom #(
  parameter int ANGLE_BITS      = cpt_pkg::DEF_ANGLE_BITS,
  parameter int SINE_TABLE_BITS = cpt_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                  clk,
  input  logic                  advance,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic signed [15:0]    sin_val,
  output logic signed [15:0]    cos_val
);

  localparam int QTR = 1 << (SINE_TABLE_BITS - 2);
  localparam int AW  = SINE_TABLE_BITS - 1;

  logic [SINE_TABLE_BITS-1:0] sin_idx;
  logic [SINE_TABLE_BITS-1:0] cos_idx;
  logic [AW-1:0]              sin_addr;
  logic [AW-1:0]              cos_addr;
  logic [14:0]                rom [0:QTR];
  logic [14:0]                sin_mag;
  logic [14:0]                cos_mag;
  logic                       sin_neg;
  logic                       cos_neg;

  // constant table contents
  for (genvar k = 0; k <= QTR; k++) begin : g_rom
    localparam logic [14:0] ENTRY = cpt_pkg::sine_entry(SINE_TABLE_BITS, k);
    assign rom[k] = ENTRY;
  end

  // table index from the top angle bits
  if (ANGLE_BITS >= SINE_TABLE_BITS) begin : g_idx_down
    assign sin_idx = angle[ANGLE_BITS-1 -: SINE_TABLE_BITS];
  end else begin : g_idx_up
    assign sin_idx = {angle, {(SINE_TABLE_BITS - ANGLE_BITS){1'b0}}};
  end

  // cosine is a quarter turn ahead
  assign cos_idx = sin_idx + SINE_TABLE_BITS'(QTR);

  // fold odd quadrants back onto the quarter wave
  always_comb begin
    if (sin_idx[SINE_TABLE_BITS-2]) begin
      sin_addr = AW'(QTR) - {1'b0, sin_idx[SINE_TABLE_BITS-3:0]};
    end else begin
      sin_addr = {1'b0, sin_idx[SINE_TABLE_BITS-3:0]};
    end
    if (cos_idx[SINE_TABLE_BITS-2]) begin
      cos_addr = AW'(QTR) - {1'b0, cos_idx[SINE_TABLE_BITS-3:0]};
    end else begin
      cos_addr = {1'b0, cos_idx[SINE_TABLE_BITS-3:0]};
    end
  end

  // registered reads, sign from the upper half turn
  always_ff @(posedge clk) begin
    if (advance) begin
      sin_mag <= rom[sin_addr];
      cos_mag <= rom[cos_addr];
      sin_neg <= sin_idx[SINE_TABLE_BITS-1];
      cos_neg <= cos_idx[SINE_TABLE_BITS-1];
    end
  end

  assign sin_val = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cos_val = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

endmodule

// ===== design/cpt_front.sv =====
// first half: clarke beta term or inverse park rotation, multiply then round
module cpt_front #(
  parameter int DATA_BITS = cpt_pkg::DEF_DATA_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  cpt_pkg::ctrl_t              ctrl_in,
  input  logic signed [DATA_BITS-1:0] x_in,
  input  logic signed [DATA_BITS-1:0] y_in,
  input  logic signed [15:0]          sin_in,
  input  logic signed [15:0]          cos_in,
  output cpt_pkg::ctrl_t              ctrl_out,
  output logic signed [DATA_BITS+1:0] alpha,
  output logic signed [DATA_BITS+1:0] beta,
  output logic signed [15:0]          sin_out,
  output logic signed [15:0]          cos_out
);

  localparam int PW = DATA_BITS + 17;
  localparam int AW = DATA_BITS + 2;

  cpt_pkg::ctrl_t           ctrl_mul;
  logic signed [16:0]       coef0;
  logic signed [16:0]       coef1;
  logic signed [PW-1:0]     m0_next;
  logic signed [PW-1:0]     m1_next;
  logic signed [PW-1:0]     m2_next;
  logic signed [PW-1:0]     m3_next;
  logic signed [PW-1:0]     m0;
  logic signed [PW-1:0]     m1;
  logic signed [PW-1:0]     m2;
  logic signed [PW-1:0]     m3;
  logic signed [DATA_BITS-1:0] x_mul;
  logic signed [15:0]       sin_mul;
  logic signed [15:0]       cos_mul;
  logic signed [PW:0]       sum_a;
  logic signed [PW:0]       sum_b;
  logic signed [AW-1:0]     alpha_next;
  logic signed [AW-1:0]     beta_next;

  // multiplier stage: clarke coefficients forward, trig terms inverse
  always_comb begin
    coef0   = ctrl_in.inverse ? {cos_in[15], cos_in} : cpt_pkg::K_INV_SQRT3;
    coef1   = ctrl_in.inverse ? {sin_in[15], sin_in} : cpt_pkg::K_TWO_INV_SQRT3;
    m0_next = x_in * coef0;
    m1_next = y_in * coef1;
    m2_next = x_in * $signed({sin_in[15], sin_in});
    m3_next = y_in * $signed({cos_in[15], cos_in});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_mul <= '0;
    end else if (advance) begin
      ctrl_mul <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m0      <= m0_next;
      m1      <= m1_next;
      m2      <= m2_next;
      m3      <= m3_next;
      x_mul   <= x_in;
      sin_mul <= sin_in;
      cos_mul <= cos_in;
    end
  end

  // round stage: sums shifted down by 15 with half-up rounding, forward alpha is x unchanged
  always_comb begin
    if (ctrl_mul.inverse) begin
      sum_a = {m0[PW-1], m0} - {m1[PW-1], m1} + (PW+1)'(cpt_pkg::ROUND_Q15);
    end else begin
      sum_a = {m0[PW-1], m0} + {m1[PW-1], m1} + (PW+1)'(cpt_pkg::ROUND_Q15);
    end
    sum_b = {m2[PW-1], m2} + {m3[PW-1], m3} + (PW+1)'(cpt_pkg::ROUND_Q15);
    if (ctrl_mul.inverse) begin
      alpha_next = sum_a[15 +: AW];
      beta_next  = sum_b[15 +: AW];
    end else begin
      alpha_next = AW'(x_mul);
      beta_next  = sum_a[15 +: AW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (advance) begin
      ctrl_out <= ctrl_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      alpha   <= alpha_next;
      beta    <= beta_next;
      sin_out <= sin_mul;
      cos_out <= cos_mul;
    end
  end

endmodule

// ===== design/cpt_back.sv =====
// second half: park rotation or inverse clarke, multiply then round and saturate
module cpt_back #(
  parameter int DATA_BITS = cpt_pkg::DEF_DATA_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  cpt_pkg::ctrl_t              ctrl_in,
  input  logic signed [DATA_BITS+1:0] alpha,
  input  logic signed [DATA_BITS+1:0] beta,
  input  logic signed [15:0]          sin_in,
  input  logic signed [15:0]          cos_in,
  output logic                        out_valid,
  output logic signed [DATA_BITS-1:0] out_first,
  output logic signed [DATA_BITS-1:0] out_second,
  output logic signed [DATA_BITS-1:0] out_third,
  output logic                        saturated
);

  localparam int AW = DATA_BITS + 2;
  localparam int QW = AW + 17;
  localparam int RW = QW + 1 - 15;

  cpt_pkg::ctrl_t        ctrl_mul;
  logic signed [16:0]    coef2;
  logic signed [16:0]    coef3;
  logic signed [QW-1:0]  n0;
  logic signed [QW-1:0]  n1;
  logic signed [QW-1:0]  n2;
  logic signed [QW-1:0]  n3;
  logic signed [QW-1:0]  n0_next;
  logic signed [QW-1:0]  n1_next;
  logic signed [QW-1:0]  n2_next;
  logic signed [QW-1:0]  n3_next;
  logic signed [AW-1:0]  alpha_mul;
  logic signed [QW:0]    sum_first;
  logic signed [QW:0]    sum_second;
  logic signed [QW:0]    sum_third;
  logic signed [RW-1:0]  first_wide;
  logic [DATA_BITS:0]    first_clip;
  logic [DATA_BITS:0]    second_clip;
  logic [DATA_BITS:0]    third_clip;

  // clip to the output range, top bit reports clipping
  function automatic logic [DATA_BITS:0] clip(input logic signed [RW-1:0] v);
    logic                 hi_ones;
    logic                 hi_zeros;
    logic                 sat;
    logic [DATA_BITS-1:0] val;
    hi_ones  = &v[RW-1:DATA_BITS-1];
    hi_zeros = ~|v[RW-1:DATA_BITS-1];
    sat      = !(hi_ones || hi_zeros);
    if (!sat) begin
      val = v[DATA_BITS-1:0];
    end else if (v[RW-1]) begin
      val = {1'b1, {(DATA_BITS-1){1'b0}}};
    end else begin
      val = {1'b0, {(DATA_BITS-1){1'b1}}};
    end
    return {sat, val};
  endfunction

  // multiplier stage: trig terms forward, inverse clarke coefficients inverse
  always_comb begin
    coef2   = ctrl_in.inverse ? cpt_pkg::K_SQRT3_HALF : {cos_in[15], cos_in};
    coef3   = ctrl_in.inverse ? cpt_pkg::K_HALF : {sin_in[15], sin_in};
    n0_next = alpha * $signed({cos_in[15], cos_in});
    n1_next = beta * $signed({sin_in[15], sin_in});
    n2_next = beta * coef2;
    n3_next = alpha * coef3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_mul <= '0;
    end else if (advance) begin
      ctrl_mul <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      n0        <= n0_next;
      n1        <= n1_next;
      n2        <= n2_next;
      n3        <= n3_next;
      alpha_mul <= alpha;
    end
  end

  // round and saturate into the output register
  always_comb begin
    sum_first  = {n0[QW-1], n0} + {n1[QW-1], n1} + (QW+1)'(cpt_pkg::ROUND_Q15);
    sum_second = {n2[QW-1], n2} - {n3[QW-1], n3} + (QW+1)'(cpt_pkg::ROUND_Q15);
    sum_third  = (QW+1)'(cpt_pkg::ROUND_Q15) - {n3[QW-1], n3} - {n2[QW-1], n2};
    if (ctrl_mul.inverse) begin
      first_wide = RW'(alpha_mul);
    end else begin
      first_wide = sum_first[15 +: RW];
    end
    first_clip  = clip(first_wide);
    second_clip = clip(sum_second[15 +: RW]);
    if (ctrl_mul.inverse) begin
      third_clip = clip(sum_third[15 +: RW]);
    end else begin
      third_clip = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctrl_mul.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_first  <= first_clip[DATA_BITS-1:0];
      out_second <= second_clip[DATA_BITS-1:0];
      out_third  <= third_clip[DATA_BITS-1:0];
      saturated  <= first_clip[DATA_BITS] | second_clip[DATA_BITS] | third_clip[DATA_BITS];
    end
  end

endmodule

// ===== design/clarke_park_transform.sv =====
// Clarke/Park transform, forward (a,b to d,q) and inverse (d,q to a,b,c), one word a
// cycle unless the output word is held. It presents each result on m_tdata through
// five register stages: the sine/cosine table read at the edge that takes the word,
// two for the first multiply and round pass, two for the second multiply, round and
// saturate pass, the last of which is the output register.
// When the output word is held by m_tready
// low the whole pipeline holds and s_tready drops in the same cycle; nothing is lost
// or repeated. Rounding is half up at every q15 step and each output saturates to
// DATA_BITS bits, with m_tuser reporting any clip.
module clarke_park_transform #(
  parameter  int DATA_BITS       = cpt_pkg::DEF_DATA_BITS,
  parameter  int ANGLE_BITS      = cpt_pkg::DEF_ANGLE_BITS,
  parameter  int SINE_TABLE_BITS = cpt_pkg::DEF_SINE_TABLE_BITS,
  localparam int IN_W            = ((ANGLE_BITS + 2 * DATA_BITS + 7) / 8) * 8,
  localparam int OUT_W           = ((3 * DATA_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // rotor_angle, first_value, second_value
  input  logic [0:0]       s_tuser,   // req_type
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_first, out_second, out_third
  output logic [0:0]       m_tuser    // saturated
);

  logic                        advance;
  logic [ANGLE_BITS-1:0]       rotor_angle;
  logic signed [DATA_BITS-1:0] first_value;
  logic signed [DATA_BITS-1:0] second_value;
  cpt_pkg::ctrl_t              ctrl_rom;
  cpt_pkg::ctrl_t              ctrl_front;
  logic signed [DATA_BITS-1:0] x_rom;
  logic signed [DATA_BITS-1:0] y_rom;
  logic signed [15:0]          sin_rom;
  logic signed [15:0]          cos_rom;
  logic signed [DATA_BITS+1:0] alpha;
  logic signed [DATA_BITS+1:0] beta;
  logic signed [15:0]          sin_front;
  logic signed [15:0]          cos_front;
  logic signed [DATA_BITS-1:0] out_first;
  logic signed [DATA_BITS-1:0] out_second;
  logic signed [DATA_BITS-1:0] out_third;
  logic                        saturated;

  // whole pipeline moves unless the output word is held
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // unpack the input word
  assign rotor_angle  = s_tdata[ANGLE_BITS-1:0];
  assign first_value  = s_tdata[ANGLE_BITS +: DATA_BITS];
  assign second_value = s_tdata[ANGLE_BITS + DATA_BITS +: DATA_BITS];

  // table read stage, operands wait beside it
  cpt_sine_rom #(
    .ANGLE_BITS      (ANGLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk     (clk),
    .advance (advance),
    .angle   (rotor_angle),
    .sin_val (sin_rom),
    .cos_val (cos_rom)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_rom <= '0;
    end else if (advance) begin
      ctrl_rom.valid   <= s_tvalid;
      ctrl_rom.inverse <= s_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_rom <= first_value;
      y_rom <= second_value;
    end
  end

  cpt_front #(
    .DATA_BITS (DATA_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .ctrl_in  (ctrl_rom),
    .x_in     (x_rom),
    .y_in     (y_rom),
    .sin_in   (sin_rom),
    .cos_in   (cos_rom),
    .ctrl_out (ctrl_front),
    .alpha    (alpha),
    .beta     (beta),
    .sin_out  (sin_front),
    .cos_out  (cos_front)
  );

  cpt_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .ctrl_in    (ctrl_front),
    .alpha      (alpha),
    .beta       (beta),
    .sin_in     (sin_front),
    .cos_in     (cos_front),
    .out_valid  (m_tvalid),
    .out_first  (out_first),
    .out_second (out_second),
    .out_third  (out_third),
    .saturated  (saturated)
  );

  // pack the output word
  always_comb begin
    m_tdata                              = '0;
    m_tdata[0 +: DATA_BITS]              = out_first;
    m_tdata[DATA_BITS +: DATA_BITS]      = out_second;
    m_tdata[2 * DATA_BITS +: DATA_BITS]  = out_third;
    m_tuser[0]                           = saturated;
  end

endmodule
